// ----- sv/positional_list_store_unit_macros.svh -----
// Assertion macros for the positional list store checker
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define PLS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define PLS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pls_pkg.sv -----
// Types and constants shared by the positional list store
package pls_pkg;

  localparam int DEPTH   = 16;
  localparam int WIDTH   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 4;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND      = 3'd0,
    FN_INSERT_AT   = 3'd1,
    FN_REMOVE_LAST = 3'd2,
    FN_REMOVE_FIRST= 3'd3,
    FN_REMOVE_AT   = 3'd4,
    FN_READ_AT     = 3'd5,
    FN_READ_FIRST  = 3'd6,
    FN_READ_LAST   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RESP
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [POS_W-1:0]   position;
    logic [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WIDTH-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- sv/pls_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module pls_ram #(
  parameter int DATA_WIDTH  = 32,
  parameter int DEPTH_WORDS = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH_WORDS)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]          wdata,
  input  logic [$clog2(DEPTH_WORDS)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]          rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pls_seq.sv -----
// Operation sequencer: decodes items, moves entries through the RAM, tracks the count
module pls_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  pls_pkg::req_t             req,
  output pls_pkg::mem_req_t         mem,
  input  logic [pls_pkg::WIDTH-1:0] rdata,
  input  logic                      res_free,
  output logic                      res_load,
  output pls_pkg::rsp_t             res
);
  import pls_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [ADDR_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0]  pos_reg, pos_reg_next;
  logic [WIDTH-1:0]   word, word_next;
  logic               is_ins, is_ins_next;
  logic               err, err_next;
  logic [DATA_W-1:0]  data, data_next;

  logic [CMP_W-1:0]   cnt_x, pos_x;
  logic [ADDR_W-1:0]  last, at;
  logic               full, empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pos_reg <= pos_reg_next;
    word    <= word_next;
    is_ins  <= is_ins_next;
    err     <= err_next;
    data    <= data_next;
  end

  always_comb begin
    cnt_x = CMP_W'(cnt);
    pos_x = CMP_W'(req.position);
    full  = (cnt == CNT_W'(DEPTH));
    empty = (cnt == '0);
    last  = ADDR_W'(cnt - 1'b1);
    at    = '0;

    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    pos_reg_next = pos_reg;
    word_next    = word;
    is_ins_next  = is_ins;
    err_next     = err;
    data_next    = data;

    req_ready = 1'b0;
    mem       = '0;
    res_load  = 1'b0;
    res.status    = err;
    res.data      = data;
    res.count     = COUNT_W'(cnt);
    res.empty_res = empty;

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          err_next     = 1'b0;
          data_next    = '0;
          word_next    = WIDTH'(req.value);
          pos_reg_next = ADDR_W'(req.position);
          state_next   = ST_RESP;
          case (req.func)
            FN_APPEND, FN_INSERT_AT: begin
              if (full) begin
                err_next = 1'b1;
              end else if (req.func == FN_INSERT_AT && pos_x < cnt_x) begin
                idx_next    = ADDR_W'(cnt);
                is_ins_next = 1'b1;
                state_next  = ST_SHIFT_RD;
              end else begin
                mem.we    = 1'b1;
                mem.waddr = ADDR_W'(cnt);
                mem.wdata = WIDTH'(req.value);
                cnt_next  = cnt + 1'b1;
              end
            end
            FN_REMOVE_LAST, FN_REMOVE_FIRST, FN_REMOVE_AT: begin
              if (empty) begin
                err_next = 1'b1;
              end else begin
                case (req.func)
                  FN_REMOVE_LAST:  at = last;
                  FN_REMOVE_FIRST: at = '0;
                  default:         at = (pos_x >= cnt_x - 1'b1) ? last
                                                               : ADDR_W'(req.position);
                endcase
                if (CMP_W'(at) + 1'b1 < cnt_x) begin
                  idx_next    = at;
                  is_ins_next = 1'b0;
                  state_next  = ST_SHIFT_RD;
                end else begin
                  cnt_next = cnt - 1'b1;
                end
              end
            end
            FN_READ_AT: begin
              if (pos_x >= cnt_x) begin
                err_next = 1'b1;
              end else begin
                mem.raddr  = ADDR_W'(req.position);
                state_next = ST_RD_WAIT;
              end
            end
            FN_READ_FIRST: begin
              if (empty) begin
                err_next = 1'b1;
              end else begin
                mem.raddr  = '0;
                state_next = ST_RD_WAIT;
              end
            end
            default: begin
              if (empty) begin
                err_next = 1'b1;
              end else begin
                mem.raddr  = last;
                state_next = ST_RD_WAIT;
              end
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        data_next  = DATA_W'(rdata);
        state_next = ST_RESP;
      end
      ST_SHIFT_RD: begin
        mem.raddr  = is_ins ? idx - 1'b1 : idx + 1'b1;
        state_next = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        mem.we    = 1'b1;
        mem.waddr = idx;
        mem.wdata = rdata;
        if (is_ins) begin
          if (idx - 1'b1 == pos_reg) begin
            state_next = ST_PUT;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = ST_SHIFT_RD;
          end
        end else begin
          if (CMP_W'(idx) + CMP_W'(2) >= cnt_x) begin
            cnt_next   = cnt - 1'b1;
            state_next = ST_RESP;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_SHIFT_RD;
          end
        end
      end
      ST_PUT: begin
        mem.we     = 1'b1;
        mem.waddr  = pos_reg;
        mem.wdata  = word;
        cnt_next   = cnt + 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/positional_list_store_unit.sv -----
// Positional list store: ordered list of up to DEPTH words with stack, queue and indexed ops
// Entries live in a RAM with one write and one read port and registered reads; an item holds the block
// from acceptance until its result is loaded into the output register, which then waits for
// the consumer while the next item is taken. Append, insert past the end, remove of the last
// entry and every error go straight to the result; reads pass through a read-wait state; insert
// at p shifts count-p entries up then writes the word, remove at a shifts count-1-a entries down,
// each shifted entry taking one RAM read and one write. No clearing pass runs after reset.
module positional_list_store_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pls_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pls_pkg::rsp_t  rsp
);
  import pls_pkg::*;

  mem_req_t          mem;
  logic [WIDTH-1:0]  rdata;
  logic              res_free;
  logic              res_load;
  rsp_t              res;

  assign res_free = !rsp_valid || rsp_ready;

  pls_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .mem       (mem),
    .rdata     (rdata),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res)
  );

  pls_ram #(
    .DATA_WIDTH  (WIDTH),
    .DEPTH_WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

// ----- sv/pls_checker.sv -----
// Port-level checker for the positional list store, bound to the top level
`include "positional_list_store_unit_macros.svh"

module pls_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input pls_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pls_pkg::rsp_t rsp
);
  import pls_pkg::*;

  `PLS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result item dropped or changed while stalled")
  `PLS_ASSERT_NOW(a_empty_flag, clk, rst, rsp_valid, rsp.empty_res == (rsp.count == '0), "empty flag disagrees with count")
  `PLS_ASSERT_NOW(a_err_data, clk, rst, rsp_valid && rsp.status, rsp.data == '0, "error result carries nonzero data")
  `PLS_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "new item taken in the cycle after an accept")

endmodule

bind positional_list_store_unit pls_checker u_pls_checker (.*);

// ----- test/positional_list_store_unit_tb.sv -----
// Self-checking testbench for the positional list store: directed edge cases, then random ops
module positional_list_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 40;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  rsp_t  rsp;

  logic [DATA_W-1:0]  list_words [DEPTH];
  logic [COUNT_W-1:0] list_len;
  rsp_t               expected_rsps [$];
  int                 fail_cnt = 0;
  int                 cycle_cnt = 0;
  bit                 calm;

  positional_list_store_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic rsp_t apply_list_op(req_t r);
    rsp_t o;
    int   n;
    int   at;
    int   i;
    o = '0;
    n = list_len;
    case (r.func)
      FN_APPEND, FN_INSERT_AT: begin
        if (n >= DEPTH) begin
          o.status = 1'b1;
        end else begin
          if (r.func == FN_INSERT_AT && r.position < n) begin
            for (i = n; i > r.position; i--) list_words[i] = list_words[i-1];
            list_words[r.position] = r.value;
          end else begin
            list_words[n] = r.value;
          end
          n++;
        end
      end
      FN_REMOVE_LAST, FN_REMOVE_FIRST, FN_REMOVE_AT: begin
        if (n == 0) begin
          o.status = 1'b1;
        end else begin
          if (r.func == FN_REMOVE_LAST) at = n - 1;
          else if (r.func == FN_REMOVE_FIRST) at = 0;
          else at = (r.position >= n - 1) ? n - 1 : r.position;
          for (i = at; i + 1 < n; i++) list_words[i] = list_words[i+1];
          n--;
        end
      end
      FN_READ_AT: begin
        if (r.position >= n) o.status = 1'b1;
        else o.data = list_words[r.position];
      end
      FN_READ_FIRST: begin
        if (n == 0) o.status = 1'b1;
        else o.data = list_words[0];
      end
      default: begin
        if (n == 0) o.status = 1'b1;
        else o.data = list_words[n-1];
      end
    endcase
    list_len    = n[COUNT_W-1:0];
    o.count     = n[COUNT_W-1:0];
    o.empty_res = (n == 0);
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (list_len > 0 && $urandom_range(0, 2) != 0) return POS_W'($urandom_range(0, list_len));
    return POS_W'($urandom_range(0, 15));
  endfunction

  function automatic int pick_gap();
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(func_t f, logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
    req_t r;
    int   gap;
    r.func     = f;
    r.position = p;
    r.value    = v;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_rsps.push_back(apply_list_op(r));
    @(negedge clk);
  endtask

  task automatic send_random_op(int add_w, int rd_w, int rm_w);
    int    roll;
    func_t f;
    roll = $urandom_range(0, add_w + rd_w + rm_w - 1);
    if (roll < add_w) f = func_t'($urandom_range(FN_APPEND, FN_INSERT_AT));
    else if (roll < add_w + rd_w) f = func_t'($urandom_range(FN_READ_AT, FN_READ_LAST));
    else f = func_t'($urandom_range(FN_REMOVE_LAST, FN_REMOVE_AT));
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    send_op(f, pick_position(), pick_word());
  endtask

  task automatic test_empty_errors();
    send_op(FN_REMOVE_LAST,  4'd0,  32'h1234_5678);
    send_op(FN_REMOVE_FIRST, 4'd0,  32'h0);
    send_op(FN_REMOVE_AT,    4'd15, 32'h0);
    send_op(FN_READ_AT,      4'd0,  32'h0);
    send_op(FN_READ_FIRST,   4'd0,  32'h0);
    send_op(FN_READ_LAST,    4'd15, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_op(FN_APPEND,       4'd0,  32'h0000_0000);
    send_op(FN_APPEND,       4'd15, 32'hFFFF_FFFF);
    send_op(FN_INSERT_AT,    4'd0,  32'hA5A5_A5A5);
    send_op(FN_INSERT_AT,    4'd15, 32'h5A5A_5A5A);
    send_op(FN_INSERT_AT,    4'd1,  32'hDEAD_BEEF);
    send_op(FN_READ_AT,      4'd0,  32'h0);
    send_op(FN_READ_AT,      4'd4,  32'h0);
    send_op(FN_READ_AT,      4'd5,  32'h0);
    send_op(FN_READ_AT,      4'd15, 32'h0);
    send_op(FN_READ_FIRST,   4'd0,  32'h0);
    send_op(FN_READ_LAST,    4'd0,  32'h0);
    send_op(FN_REMOVE_AT,    4'd1,  32'h0);
    send_op(FN_REMOVE_AT,    4'd15, 32'h0);
    send_op(FN_REMOVE_FIRST, 4'd0,  32'h0);
    send_op(FN_REMOVE_LAST,  4'd0,  32'h0);
    send_op(FN_REMOVE_AT,    4'd0,  32'h0);
  endtask

  task automatic test_fill_and_drain(int n_items);
    bit growing;
    int k;
    growing = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (growing) send_random_op(65, 20, 15);
      else send_random_op(15, 20, 65);
      if (list_len == DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
      if (list_len == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
    end
  endtask

  task automatic test_random_mix(int n_items);
    int k;
    for (k = 0; k < n_items; k++) send_random_op(40, 30, 30);
  endtask

  task automatic test_back_to_back(int n_items);
    int k;
    calm = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      send_op(func_t'($urandom_range(0, 7)), pick_position(), pick_word());
    end
    calm = 1'b0;
  endtask

  initial begin
    int gap;
    rsp_ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no item outstanding: %p", rsp);
        fail_cnt++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fail_cnt++;
        end
        if (rsp.data !== want.data) begin
          $error("data: expected %h, got %h", want.data, rsp.data);
          fail_cnt++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp.count);
          fail_cnt++;
        end
        if (rsp.empty_res !== want.empty_res) begin
          $error("empty_res: expected %0d, got %0d", want.empty_res, rsp.empty_res);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[positional_list_store_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    calm      = 1'b0;
    list_len  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_errors();
    test_basic_ops();
    test_fill_and_drain(700);
    test_random_mix(800);
    test_back_to_back(330);

    req_valid = 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[positional_list_store_unit] OK");
    end else begin
      $display("[positional_list_store_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/pls_pkg.sv
sv/pls_ram.sv
sv/pls_seq.sv
sv/positional_list_store_unit.sv
sv/pls_checker.sv
test/positional_list_store_unit_tb.sv
